@@ rtl/f16map_pkg.sv @@
// ----------------------------------------------------------------------------
// f16map_pkg
// Shared constants for the FAT16 file read mapper.
// ----------------------------------------------------------------------------
package f16map_pkg;

	localparam int FAT_ENTRIES = 4096;
	localparam int FAT_AW      = $clog2(FAT_ENTRIES);
	localparam int MAX_READ    = 16384;

	localparam logic [15:0] CHAIN_END   = 16'hFFF8;
	localparam logic [12:0] BPS_MIN     = 13'd512;
	localparam logic [12:0] BPS_MAX     = 13'd4096;
	localparam logic [7:0]  SPC_MAX     = 8'd128;

	localparam logic [1:0] REG_DATA_START = 2'd0;
	localparam logic [1:0] REG_SPC        = 2'd1;
	localparam logic [1:0] REG_BPS        = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

endpackage

@@ rtl/fat16_file_read_mapper.sv @@
// ----------------------------------------------------------------------------
// fat16_file_read_mapper
// Per read chunk: two 32-step serial divisions (offset by sector bytes, then
// sectors by sectors per cluster), a chain walk of one table read per step with
// bounds and end checks, a multiply and an emit, where steps = offset / cluster
// bytes. Loads and zero-length reads are handled in idle. One word at a time;
// busy is high until the last result strobes out. Reset clears control state
// and registers; the table is undefined until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module fat16_file_read_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [11:0] entry_index,
	input  logic [15:0] entry_value,
	input  logic [15:0] first_cluster,
	input  logic [31:0] byte_offset,
	input  logic [14:0] read_length,
	output logic        done,
	output logic [31:0] sector_address,
	output logic [11:0] byte_in_sector,
	output logic [12:0] chunk_length,
	output logic [14:0] buffer_position,
	output logic        chain_error,
	output logic        last
);
	import f16map_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV1, S_DIV2, S_WALK, S_WAIT, S_MUL, S_EMIT
	} state_t;

	state_t state_q;

	logic [31:0] drs_q;
	logic [7:0]  spc_cfg_q;
	logic [12:0] bps_cfg_q;

	logic [7:0]  spc_q;
	logic [12:0] bps_q;
	logic [15:0] start_q;
	logic [15:0] walk_q;
	logic [31:0] offset_q;
	logic [14:0] remain_q;
	logic [14:0] pos_q;
	logic [11:0] byte_q;
	logic [7:0]  secin_q;
	logic [12:0] steps_q;
	logic [31:0] prod_q;

	logic [31:0] num_q;
	logic [12:0] rem_q;
	logic [12:0] den_q;
	logic [4:0]  cnt_q;

	logic [15:0] fat_mem [FAT_ENTRIES];
	logic [15:0] rd_q;

	logic [13:0] div_t;
	logic        div_ge;
	logic [12:0] div_r;
	logic [7:0]  spc_sat;
	logic [12:0] bps_sat;
	logic [14:0] len_sat;
	logic [12:0] room;
	logic [12:0] chunk;
	logic [14:0] remain_nx;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		div_t  = {rem_q, num_q[31]};
		div_ge = (div_t >= {1'b0, den_q});
		div_r  = div_ge ? 13'(div_t - {1'b0, den_q}) : div_t[12:0];
		spc_sat = (spc_cfg_q == 8'd0) ? 8'd1 : ((spc_cfg_q > SPC_MAX) ? SPC_MAX : spc_cfg_q);
		bps_sat = (bps_cfg_q < BPS_MIN) ? BPS_MIN :
			((bps_cfg_q > BPS_MAX) ? BPS_MAX : bps_cfg_q);
		len_sat = (read_length > 15'(MAX_READ)) ? 15'(MAX_READ) : read_length;
		room  = bps_q - {1'b0, byte_q};
		chunk = ({2'b0, room} > remain_q) ? remain_q[12:0] : room;
		remain_nx = remain_q - {2'b0, chunk};
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && cmd == CMD_LOAD)
			fat_mem[entry_index] <= entry_value;
		rd_q <= fat_mem[walk_q[FAT_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drs_q     <= '0;
			spc_cfg_q <= 8'd1;
			bps_cfg_q <= BPS_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DATA_START: drs_q     <= cfg_data;
				REG_SPC:        spc_cfg_q <= cfg_data[7:0];
				REG_BPS:        bps_cfg_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			done            <= 1'b0;
			sector_address  <= '0;
			byte_in_sector  <= '0;
			chunk_length    <= '0;
			buffer_position <= '0;
			chain_error     <= 1'b0;
			last            <= 1'b0;
			spc_q <= 8'd1; bps_q <= BPS_MIN; start_q <= '0; walk_q <= '0;
			offset_q <= '0; remain_q <= '0; pos_q <= '0; byte_q <= '0;
			secin_q <= '0; steps_q <= '0; prod_q <= '0;
			num_q <= '0; rem_q <= '0; den_q <= '0; cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && cmd == CMD_READ) begin
						spc_q    <= spc_sat;
						bps_q    <= bps_sat;
						start_q  <= first_cluster;
						offset_q <= byte_offset;
						remain_q <= len_sat;
						pos_q    <= '0;
						if (len_sat == '0) begin
							done            <= 1'b1;
							sector_address  <= '0;
							byte_in_sector  <= '0;
							chunk_length    <= '0;
							buffer_position <= '0;
							chain_error     <= 1'b0;
							last            <= 1'b1;
						end else begin
							done    <= 1'b0;
							num_q   <= byte_offset;
							rem_q   <= '0;
							den_q   <= bps_sat;
							cnt_q   <= '1;
							state_q <= S_DIV1;
						end
					end else begin
						done <= 1'b0;
					end
				end
				S_DIV1: begin
					done <= 1'b0;
					if (cnt_q == '0) begin
						byte_q  <= div_r[11:0];
						num_q   <= {num_q[30:0], div_ge};
						rem_q   <= '0;
						den_q   <= {5'b0, spc_q};
						cnt_q   <= '1;
						state_q <= S_DIV2;
					end else begin
						num_q <= {num_q[30:0], div_ge};
						rem_q <= div_r;
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_DIV2: begin
					num_q <= {num_q[30:0], div_ge};
					rem_q <= div_r;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						secin_q <= div_r[7:0];
						walk_q  <= start_q;
						if ({num_q[30:0], div_ge} > 32'(FAT_ENTRIES)) begin
							done            <= 1'b1;
							sector_address  <= '0;
							byte_in_sector  <= byte_q;
							chunk_length    <= '0;
							buffer_position <= pos_q;
							chain_error     <= 1'b1;
							last            <= 1'b1;
							state_q         <= S_IDLE;
						end else begin
							done    <= 1'b0;
							steps_q <= 13'({num_q[30:0], div_ge});
							state_q <= S_WALK;
						end
					end else begin
						done <= 1'b0;
					end
				end
				S_WALK: begin
					if (steps_q == '0) begin
						done    <= 1'b0;
						state_q <= S_MUL;
					end else if (walk_q >= 16'(FAT_ENTRIES)) begin
						done            <= 1'b1;
						sector_address  <= '0;
						byte_in_sector  <= byte_q;
						chunk_length    <= '0;
						buffer_position <= pos_q;
						chain_error     <= 1'b1;
						last            <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						done    <= 1'b0;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (rd_q >= CHAIN_END) begin
						done            <= 1'b1;
						sector_address  <= '0;
						byte_in_sector  <= byte_q;
						chunk_length    <= '0;
						buffer_position <= pos_q;
						chain_error     <= 1'b1;
						last            <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						done    <= 1'b0;
						walk_q  <= rd_q;
						steps_q <= steps_q - 13'd1;
						state_q <= S_WALK;
					end
				end
				S_MUL: begin
					done    <= 1'b0;
					prod_q  <= 32'({24'b0, spc_q} * ({16'b0, walk_q} - 32'd2));
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					done            <= 1'b1;
					sector_address  <= prod_q + drs_q + {24'b0, secin_q};
					byte_in_sector  <= byte_q;
					chunk_length    <= chunk;
					buffer_position <= pos_q;
					chain_error     <= 1'b0;
					last            <= (remain_nx == '0);
					remain_q        <= remain_nx;
					pos_q           <= pos_q + {2'b0, chunk};
					offset_q        <= offset_q + {19'b0, chunk};
					if (remain_nx == '0) begin
						state_q <= S_IDLE;
					end else begin
						num_q   <= offset_q + {19'b0, chunk};
						rem_q   <= '0;
						den_q   <= bps_q;
						cnt_q   <= '1;
						state_q <= S_DIV1;
					end
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ bench/fat16_file_read_mapper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat16_file_read_mapper_tb
// Loads allocation table entries and issues file reads to the mapper, then
// checks every chunk result against a cluster-chain predictor kept in the
// bench. Reads only follow chains through loaded entries; a missing link is
// loaded first. Runs a directed table and then random words under several
// cluster and sector geometries, with bursty start traffic.
// ----------------------------------------------------------------------------
module fat16_file_read_mapper_tb;
	import f16map_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int ROUNDS         = 6;
	localparam int WORDS_PER_ROUND = 64;

	typedef struct packed {
		logic [31:0] sec;
		logic [11:0] byt;
		logic [12:0] len;
		logic [14:0] pos;
		logic        err;
		logic        last;
	} chunk_t;

	typedef struct packed {
		logic        op;
		logic [11:0] idx;
		logic [15:0] val;
		logic [15:0] sc;
		logic [31:0] off;
		logic [14:0] rl;
		logic        typed;
		chunk_t      want;
	} script_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [11:0] entry_index;
	logic [15:0] entry_value;
	logic [15:0] first_cluster;
	logic [31:0] byte_offset;
	logic [14:0] read_length;
	logic        done;
	logic [31:0] sector_address;
	logic [11:0] byte_in_sector;
	logic [12:0] chunk_length;
	logic [14:0] buffer_position;
	logic        chain_error;
	logic        last;

	logic [15:0] fat_image [FAT_ENTRIES];
	bit          fat_loaded [FAT_ENTRIES];
	logic [31:0] data_start_q;
	logic [7:0]  spc_q;
	logic [12:0] bps_q;

	chunk_t      expected_chunks [$];
	chunk_t      walk_chunks [$];
	int          mismatches;
	int          idle_cycles;
	int          burst_left;
	script_t     script [20];

	fat16_file_read_mapper dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy), .cmd(cmd),
		.entry_index(entry_index), .entry_value(entry_value),
		.first_cluster(first_cluster), .byte_offset(byte_offset),
		.read_length(read_length), .done(done), .sector_address(sector_address),
		.byte_in_sector(byte_in_sector), .chunk_length(chunk_length),
		.buffer_position(buffer_position), .chain_error(chain_error), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Fill walk_chunks with the chunks of one read. Returns the first
	// unloaded entry the walk would touch, or -1.
	function automatic int map_read(input logic [15:0] sc, input logic [31:0] off_in,
			input logic [14:0] rl);
		logic [31:0] spc, bps, clus, steps, secin, byt, chunk, rem, pos, cl, off;
		logic        ok;
		int          i;
		walk_chunks = {};
		spc = (spc_q == 0) ? 32'd1 : ((spc_q > SPC_MAX) ? 32'(SPC_MAX) : 32'(spc_q));
		bps = (bps_q < BPS_MIN) ? 32'(BPS_MIN) : ((bps_q > BPS_MAX) ? 32'(BPS_MAX) : 32'(bps_q));
		clus = bps * spc;
		rem = (rl > MAX_READ) ? MAX_READ : 32'(rl);
		pos = 0;
		off = off_in;
		if (rem == 0) begin
			walk_chunks.push_back('{sec: 0, byt: 0, len: 0, pos: 0, err: 0, last: 1});
			return -1;
		end
		while (rem > 0) begin
			steps = off / clus;
			secin = (off / bps) % spc;
			byt = off % bps;
			chunk = bps - byt;
			if (chunk > rem)
				chunk = rem;
			cl = 32'(sc);
			ok = (steps <= FAT_ENTRIES);
			i = 0;
			while (ok && i < steps) begin
				if (cl >= FAT_ENTRIES) begin
					ok = 1'b0;
				end else begin
					if (!fat_loaded[cl[FAT_AW-1:0]])
						return int'(cl);
					cl = 32'(fat_image[cl[FAT_AW-1:0]]);
					if (cl >= 32'(CHAIN_END))
						ok = 1'b0;
				end
				i++;
			end
			if (!ok) begin
				walk_chunks.push_back('{sec: 0, byt: byt[11:0], len: 0, pos: pos[14:0],
					err: 1, last: 1});
				return -1;
			end
			rem = rem - chunk;
			walk_chunks.push_back('{sec: spc * (cl - 32'd2) + data_start_q + secin,
				byt: byt[11:0], len: chunk[12:0], pos: pos[14:0], err: 0, last: rem == 0});
			pos = pos + chunk;
			off = off + chunk;
		end
		return -1;
	endfunction

	// Enter and leave at a falling edge.
	task automatic send_word(input logic op, input logic [11:0] idx, input logic [15:0] val,
			input logic [15:0] sc, input logic [31:0] off, input logic [14:0] rl);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		start = 1'b1;
		cmd = op;
		entry_index = idx;
		entry_value = val;
		first_cluster = sc;
		byte_offset = off;
		read_length = rl;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		if (op == CMD_LOAD) begin
			fat_image[idx] = val;
			fat_loaded[idx] = 1'b1;
		end
		start = 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		while (expected_chunks.size() != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_DATA_START: data_start_q = data;
			REG_SPC: spc_q = data[7:0];
			REG_BPS: bps_q = data[12:0];
			default: ;
		endcase
	endtask

	// Load any missing links first, then issue the read.
	task automatic issue_read(input logic [15:0] sc, input logic [31:0] off,
			input logic [14:0] rl);
		int          missing;
		logic [15:0] link;
		missing = map_read(sc, off, rl);
		while (missing >= 0) begin
			case ($urandom_range(0, 19))
				0, 1, 2: link = 16'hFFF8 | 16'($urandom_range(0, 7));
				3, 4: link = 16'($urandom_range(FAT_ENTRIES, 16'hFFF7));
				5, 6, 7: link = 16'($urandom);
				default: link = 16'($urandom_range(2, 63));
			endcase
			send_word(CMD_LOAD, 12'(missing), link, 16'($urandom), $urandom, 15'($urandom));
			missing = map_read(sc, off, rl);
		end
		send_word(CMD_READ, 12'($urandom), 16'($urandom), sc, off, rl);
		foreach (walk_chunks[k])
			expected_chunks.push_back(walk_chunks[k]);
	endtask

	always @(posedge clk) begin
		chunk_t got, want;
		if (arst_n && done) begin
			got = '{sec: sector_address, byt: byte_in_sector, len: chunk_length,
				pos: buffer_position, err: chain_error, last: last};
			if (expected_chunks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected chunk: sec %h byte %0d len %0d pos %0d err %b last %b",
						got.sec, got.byt, got.len, got.pos, got.err, got.last);
			end else begin
				want = expected_chunks.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("chunk mismatch: exp sec %h byte %0d len %0d pos %0d err %b last %b",
							want.sec, want.byt, want.len, want.pos, want.err, want.last);
						$display("                got sec %h byte %0d len %0d pos %0d err %b last %b",
							got.sec, got.byt, got.len, got.pos, got.err, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] clus, off;
		logic [15:0] sc;
		logic [14:0] rl;
		logic [31:0] bps_eff;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DATA_START;
		cfg_data = '0;
		start = 1'b0;
		cmd = CMD_LOAD;
		entry_index = '0;
		entry_value = '0;
		first_cluster = '0;
		byte_offset = '0;
		read_length = '0;
		data_start_q = '0;
		spc_q = 8'd1;
		bps_q = 13'd512;
		foreach (fat_loaded[k]) begin
			fat_loaded[k] = 1'b0;
			fat_image[k] = '0;
		end

		script = '{
			'{CMD_LOAD, 12'd2, 16'd3, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd3, 16'hFFFF, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd4, 16'd5, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd5, 16'd4, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd6, 16'h1000, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd4095, 16'd0, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd7, 16'hFFF8, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_LOAD, 12'd8, 16'd7, 16'd0, 32'd0, 15'd0, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd3, 32'd7, 15'd0, 1'b1,
				'{sec: 0, byt: 0, len: 0, pos: 0, err: 0, last: 1}},
			'{CMD_READ, 12'd0, 16'd0, 16'd2, 32'hFFFF_FFFF, 15'd1, 1'b1,
				'{sec: 0, byt: 511, len: 0, pos: 0, err: 1, last: 1}},
			'{CMD_READ, 12'd0, 16'd0, 16'd5, 32'hFFFF_FFFF, 15'h7FFF, 1'b1,
				'{sec: 0, byt: 511, len: 0, pos: 0, err: 1, last: 1}},
			'{CMD_READ, 12'd0, 16'd0, 16'd2, 32'd0, 15'd1, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd2, 32'd100, 15'd16384, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd4, 32'd0, 15'h7FFF, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd6, 32'd1024, 15'd600, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd8, 32'd512, 15'd10, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd7, 32'd512, 15'd1, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd0, 32'd0, 15'd5, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'hFFFF, 32'd0, 15'd1, 1'b0, '0},
			'{CMD_READ, 12'd0, 16'd0, 16'd4095, 32'd511, 15'd2, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[r]) begin
			send_word(script[r].op, script[r].idx, script[r].val, script[r].sc,
				script[r].off, script[r].rl);
			if (script[r].op == CMD_READ) begin
				if (script[r].typed) begin
					expected_chunks.push_back(script[r].want);
				end else begin
					void'(map_read(script[r].sc, script[r].off, script[r].rl));
					foreach (walk_chunks[k])
						expected_chunks.push_back(walk_chunks[k]);
				end
			end
		end

		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
				0: begin
					write_reg(REG_DATA_START, 32'h0000_1000);
					write_reg(REG_SPC, 32'd4);
					write_reg(REG_BPS, 32'd512);
				end
				1: begin
					write_reg(REG_DATA_START, 32'hFFFF_FFF0);
					write_reg(REG_SPC, 32'd128);
					write_reg(REG_BPS, 32'd4096);
				end
				2: begin
					write_reg(REG_DATA_START, $urandom);
					write_reg(REG_SPC, 32'd0);
					write_reg(REG_BPS, 32'd100);
				end
				3: begin
					write_reg(REG_DATA_START, $urandom);
					write_reg(REG_SPC, 32'hFFFF_FFFF);
					write_reg(REG_BPS, 32'hFFFF_FFFF);
				end
				4: begin
					write_reg(REG_DATA_START, 32'd0);
					write_reg(REG_SPC, 32'd1);
					write_reg(REG_BPS, 32'd512);
				end
				default: begin
					write_reg(REG_DATA_START, $urandom);
					write_reg(REG_SPC, $urandom_range(1, 16));
					write_reg(REG_BPS, $urandom_range(1024, 2048));
				end
			endcase
			bps_eff = (bps_q < BPS_MIN) ? 32'(BPS_MIN)
				: ((bps_q > BPS_MAX) ? 32'(BPS_MAX) : 32'(bps_q));
			clus = bps_eff * ((spc_q == 0) ? 32'd1
				: ((spc_q > SPC_MAX) ? 32'(SPC_MAX) : 32'(spc_q)));
			for (int n = 0; n < WORDS_PER_ROUND; n++) begin
				if ($urandom_range(0, 9) < 3) begin
					send_word(CMD_LOAD, 12'($urandom), 16'($urandom), 16'($urandom),
						$urandom, 15'($urandom));
				end else begin
					case ($urandom_range(0, 9))
						0: sc = 16'($urandom);
						1: sc = 16'($urandom_range(0, 1));
						default: sc = 16'($urandom_range(2, 63));
					endcase
					case ($urandom_range(0, 19))
						0: off = $urandom | 32'hF000_0000;
						1: off = 32'hFFFF_FFFF - $urandom_range(0, 8191);
						default: off = $urandom_range(0, 6) * clus + $urandom_range(0, clus - 1);
					endcase
					case ($urandom_range(0, 9))
						0: rl = 15'd0;
						1: rl = 15'($urandom);
						2: rl = 15'd16384;
						default: rl = 15'($urandom_range(1, 3 * bps_eff));
					endcase
					issue_read(sc, off, rl);
				end
			end
		end

		while (expected_chunks.size() != 0 || busy)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0 && expected_chunks.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/f16map_pkg.sv
rtl/fat16_file_read_mapper.sv
bench/fat16_file_read_mapper_tb.sv
